>>> src/sida_pkg.sv
// ----------------------------------------------------------------------------
// sida_pkg
// Shared constants and controller/datapath interface types for the signed
// integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sida_pkg;

	localparam int unsigned VALUE_W    = 32;
	localparam int unsigned CHAR_W     = 8;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned MAX_DIGITS = 10;
	localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);
	// Quotient of a 32-bit magnitude by ten fits in 29 bits
	localparam int unsigned QUOT_W     = 29;
	localparam int unsigned PROD_W     = 2 * VALUE_W;

	// Reciprocal of ten: floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for 32-bit x
	localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int unsigned        RECIP_SHIFT = 35;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;   // capture a new value, form its magnitude
		logic mul;    // multiply magnitude by the reciprocal
		logic rem;    // form the digit, push it, advance the magnitude
		logic pop;    // drop the character just delivered
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic quot_zero;  // quotient is zero: no more digits
		logic last_char;  // current output character ends the run
	} status_t;

endpackage

>>> src/sida_datapath.sv
// ----------------------------------------------------------------------------
// sida_datapath
// Magnitude, reciprocal divide-by-ten, digit stack and output character select.
// ----------------------------------------------------------------------------
module sida_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sida_pkg::cmd_t                     cmd,
	input  logic        [sida_pkg::VALUE_W-1:0] value,
	output sida_pkg::status_t                  status,
	output logic        [sida_pkg::CHAR_W-1:0]  character,
	output logic                               last
);

	logic [sida_pkg::VALUE_W-1:0] mag_q;
	logic [sida_pkg::QUOT_W-1:0]  quot_q;
	logic [sida_pkg::PROD_W-1:0]  prod;
	logic [sida_pkg::DIGIT_W-1:0] stack_q [sida_pkg::MAX_DIGITS];
	logic [sida_pkg::DIGIT_W-1:0] digit;
	logic [sida_pkg::DIGIT_W-1:0] quot_x10_lo;
	logic [sida_pkg::CNT_W-1:0]   cnt_q;
	logic                         sign_q;

	assign prod = sida_pkg::PROD_W'(mag_q) * sida_pkg::PROD_W'(sida_pkg::RECIP_TEN);

	// Remainder is below ten, so the low nibble of mag - 10*q is exact
	assign quot_x10_lo = sida_pkg::DIGIT_W'({quot_q, 3'b000} + {quot_q, 1'b0});
	assign digit       = mag_q[sida_pkg::DIGIT_W-1:0] - quot_x10_lo;

	assign status.quot_zero = (quot_q == '0);
	assign status.last_char = !sign_q && (cnt_q == sida_pkg::CNT_W'(1));

	assign character = sign_q ? sida_pkg::ASCII_MINUS
	                          : (sida_pkg::ASCII_ZERO + sida_pkg::CHAR_W'(stack_q[0]));
	assign last      = status.last_char;

	// Control part: digit count and pending minus sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			sign_q <= 1'b0;
		end else if (cmd.load) begin
			cnt_q  <= '0;
			sign_q <= value[sida_pkg::VALUE_W-1];
		end else if (cmd.rem) begin
			cnt_q <= cnt_q + sida_pkg::CNT_W'(1);
		end else if (cmd.pop) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - sida_pkg::CNT_W'(1);
			end
		end
	end

	// Payload part: magnitude, quotient and digit stack
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= value[sida_pkg::VALUE_W-1] ? (~value + sida_pkg::VALUE_W'(1)) : value;
		end
		if (cmd.mul) begin
			quot_q <= prod[sida_pkg::RECIP_SHIFT +: sida_pkg::QUOT_W];
		end
		if (cmd.rem) begin
			mag_q      <= sida_pkg::VALUE_W'(quot_q);
			stack_q[0] <= digit;
			for (int i = 1; i < sida_pkg::MAX_DIGITS; i++) begin
				stack_q[i] <= stack_q[i-1];
			end
		end else if (cmd.pop && !sign_q) begin
			for (int i = 0; i < sida_pkg::MAX_DIGITS - 1; i++) begin
				stack_q[i] <= stack_q[i+1];
			end
			stack_q[sida_pkg::MAX_DIGITS-1] <= '0;
		end
	end

endmodule

>>> src/sida_ctrl.sv
// ----------------------------------------------------------------------------
// sida_ctrl
// Sequencer: accept a value, run the divide loop, stream out the characters.
// ----------------------------------------------------------------------------
module sida_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  sida_pkg::status_t status,
	output sida_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_REM  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_EMIT);

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_REM;
			end
			ST_REM: begin
				cmd.rem = 1'b1;
				state_d = status.quot_zero ? ST_EMIT : ST_MUL;
			end
			ST_EMIT: begin
				if (m_tready) begin
					cmd.pop = 1'b1;
					if (status.last_char) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> src/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a 32-bit two's complement integer to its decimal ASCII text,
// most significant character first, with tlast on the final character.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Fields                        Accepted when
// s_*      in   tdata[31:0] value (signed)    s_tvalid && s_tready
// m_*      out  tdata[7:0] character, tlast   m_tvalid && m_tready
//
// An item with n digits (1..10) is accepted, then runs the divide loop
// (reciprocal multiply, then remainder and digit push, once per digit) and
// then delivers one character per cycle while m_tready is high.
// One item is in flight at a time: s_tready is high only when idle.
// m_tready low holds the current character; nothing else advances.
// arst_n returns the sequencer to idle with no run pending.
//
module signed_int_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] character
	output logic        m_tlast
);

	sida_pkg::cmd_t    cmd;
	sida_pkg::status_t status;

	// Sequencer: owns both handshakes and steps the datapath
	sida_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: magnitude, divide by ten, digit stack, character select
	sida_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (s_tdata),
		.status    (status),
		.character (m_tdata),
		.last      (m_tlast)
	);

`ifndef SYNTHESIS
	// Input is never taken while a run is still being delivered
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input accepted during output run");

	// A delivered character is always a minus sign or a decimal digit
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata == sida_pkg::ASCII_MINUS) ||
		              ((m_tdata >= sida_pkg::ASCII_ZERO) &&
		               (m_tdata <= sida_pkg::ASCII_NINE))))
		else $error("bad output character");

	// The run never ends on the minus sign
	a_last_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tdata != sida_pkg::ASCII_MINUS))
		else $error("run ends on minus sign");

	// After the final character the block returns to idle
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
		else $error("no return to idle after last character");
`endif

endmodule
